FILE: hw/rtl/tcpq_pkg.sv
// Package for the three-class priority queue.
// Holds item types, cell types, class and status codes and fixed widths.
// No dependencies.
package tcpq_pkg;

    // fixed sizes
    localparam int NUM_CLASSES   = 3;
    localparam int CLASS_DEPTH   = 16;   // default entries per class
    localparam int PAYLOAD_BITS  = 32;
    localparam int CLS_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int TOTAL_W       = 6;

    // commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // classes, highest priority first
    localparam logic [CLS_W-1:0] CLS_EXPRESS  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_STANDARD = 2'd1;
    localparam logic [CLS_W-1:0] CLS_FREE     = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // input item
    typedef struct packed {
        logic                    cmd;
        logic [CLS_W-1:0]        prio_class;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_in;

    // result item
    typedef struct packed {
        logic                    pop_valid;
        logic [CLS_W-1:0]        pop_class;
        logic [PAYLOAD_BITS-1:0] pop_payload;
        logic [STATUS_W-1:0]     status;
        logic [TOTAL_W-1:0]      total_count;
    } t_out;

    // contents of one cell
    typedef struct packed {
        logic                    vld;
        logic [CLS_W-1:0]        cls;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic                    push;
        logic                    pop;
        logic [CLS_W-1:0]        cls;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/three_class_priority_queue_top.sv
// Three-class strict priority queue, top level.
// Built from a chain of tcpq_cell instances and per-class fill counters.
// Depends on tcpq_pkg and tcpq_cell.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries a t_in item: a push of a
//   payload into class express, standard or free (class 3 counts as free),
//   or a pop. Output channel o_out_valid / i_out_stall returns one t_out
//   result per item: popped record, status and the entries held afterwards.
//   The queue is a row of 3*CLASS_DEPTH cells kept sorted by class, oldest
//   first within a class; cell 0 is always the next record to pop. A push
//   opens a gap behind the last entry of its class, a pop shifts every cell
//   one place forward, both in one update of the cell row.
//   Latency: the result is registered and appears the cycle after the item
//   is accepted. Throughput: one item per cycle while the output is not
//   stalled, set by the single update of the cell row per cycle.
//   While a result waits under i_out_stall, o_in_stall is raised; an item
//   may still be accepted in the cycle the waiting result is taken.
//   Reset (i_rst_n low, synchronous) empties every cell and clears the class
//   counters and the output valid flag; no clearing pass is needed.
module three_class_priority_queue_top #(
    parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tcpq_pkg::t_in  i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tcpq_pkg::t_out o_out_item
);

    localparam int NCELLS = tcpq_pkg::NUM_CLASSES * CLASS_DEPTH;
    localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 2;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CLASS_DEPTH);

    tcpq_pkg::t_entry    w_ent [NCELLS];
    tcpq_pkg::t_entry    w_left [NCELLS];
    tcpq_pkg::t_entry    w_right [NCELLS];
    tcpq_pkg::t_cell_ctl ctl;

    logic [CNT_W-1:0] r_cnt [tcpq_pkg::NUM_CLASSES];
    logic [CNT_W-1:0] n_cnt [tcpq_pkg::NUM_CLASSES];
    tcpq_pkg::t_out   r_out;
    tcpq_pkg::t_out   n_out;
    logic             r_out_vld;

    logic                       accept;
    logic                       is_pop;
    logic [tcpq_pkg::CLS_W-1:0] push_cls;
    logic                       push_ok;
    logic                       pop_ok;
    logic [SUM_W-1:0]           cur_total;
    logic [SUM_W-1:0]           new_total;

    // handshake: take an item whenever the output register is free or leaving
    assign o_in_stall  = r_out_vld && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // decode; out-of-range class saturates to free
    assign is_pop   = (i_in_item.cmd == tcpq_pkg::CMD_POP);
    assign push_cls = (i_in_item.prio_class > tcpq_pkg::CLS_FREE) ?
                      tcpq_pkg::CLS_FREE : i_in_item.prio_class;
    assign push_ok  = accept && !is_pop && (r_cnt[push_cls] != CNT_FULL);
    assign pop_ok   = accept && is_pop && w_ent[0].vld;

    // broadcast to the cells
    always_comb begin
        ctl.push    = push_ok;
        ctl.pop     = pop_ok;
        ctl.cls     = push_cls;
        ctl.payload = i_in_item.payload;
    end

    // neighbour wiring; the front cell sees an always-ahead entry on its left
    always_comb begin
        for (int i = 0; i < NCELLS; i++) begin
            if (i == 0) begin
                w_left[i].vld     = 1'b1;
                w_left[i].cls     = tcpq_pkg::CLS_EXPRESS;
                w_left[i].payload = '0;
            end else begin
                w_left[i] = w_ent[i-1];
            end
            if (i == NCELLS - 1) begin
                w_right[i] = '0;
            end else begin
                w_right[i] = w_ent[i+1];
            end
        end
    end

    // the cell chain
    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        tcpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_entry (w_ent[g])
        );
    end

    // per-class counters
    always_comb begin
        for (int c = 0; c < tcpq_pkg::NUM_CLASSES; c++) begin
            n_cnt[c] = r_cnt[c];
            if (push_ok && (push_cls == tcpq_pkg::CLS_W'(c))) begin
                n_cnt[c] = r_cnt[c] + CNT_W'(1);
            end
            if (pop_ok && (w_ent[0].cls == tcpq_pkg::CLS_W'(c))) begin
                n_cnt[c] = r_cnt[c] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < tcpq_pkg::NUM_CLASSES; c++) begin
                r_cnt[c] <= '0;
            end
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign cur_total = SUM_W'(r_cnt[0]) + SUM_W'(r_cnt[1]) + SUM_W'(r_cnt[2]);
    assign new_total = SUM_W'(n_cnt[0]) + SUM_W'(n_cnt[1]) + SUM_W'(n_cnt[2]);

    // result of the current item
    always_comb begin
        n_out.pop_valid   = pop_ok;
        n_out.pop_class   = pop_ok ? w_ent[0].cls : tcpq_pkg::CLS_EXPRESS;
        n_out.pop_payload = pop_ok ? w_ent[0].payload : '0;
        n_out.total_count = tcpq_pkg::TOTAL_W'(new_total);
        if (is_pop) begin
            n_out.status = w_ent[0].vld ? tcpq_pkg::ST_OK : tcpq_pkg::ST_EMPTY;
        end else begin
            n_out.status = (r_cnt[push_cls] == CNT_FULL) ?
                           tcpq_pkg::ST_FULL : tcpq_pkg::ST_OK;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (accept) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // front cell holds an entry exactly when the counters say the queue is not empty
    a_front_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ent[0].vld == (cur_total != '0))
        else $error("front cell disagrees with class counters");

    // a pop on an empty queue reports empty and returns nothing
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_pop && !w_ent[0].vld) |=>
        (r_out.status == tcpq_pkg::ST_EMPTY) && !r_out.pop_valid)
        else $error("empty pop not flagged");

    // an accepted item always leaves a result waiting
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_vld)
        else $error("accepted item produced no result");

    // no class counter ever exceeds its class depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CNT_FULL) && (r_cnt[1] <= CNT_FULL) && (r_cnt[2] <= CNT_FULL))
        else $error("class counter overflow");

endmodule

FILE: hw/rtl/tcpq_cell.sv
// One cell of the sorted queue chain.
// Holds one entry; shifts towards the front on a pop, makes room on a push.
// Depends on tcpq_pkg.
module tcpq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcpq_pkg::t_cell_ctl i_ctl,
    input  tcpq_pkg::t_entry    i_left,
    input  tcpq_pkg::t_entry    i_right,
    output tcpq_pkg::t_entry    o_entry
);

    tcpq_pkg::t_entry r_entry;
    tcpq_pkg::t_entry n_entry;
    logic             self_stays;
    logic             left_stays;

    // entries of the same or a higher class stay ahead of a new push
    assign self_stays = r_entry.vld && (r_entry.cls <= i_ctl.cls);
    assign left_stays = i_left.vld  && (i_left.cls  <= i_ctl.cls);

    // next contents
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.pop) begin
            n_entry = i_right;
        end else if (i_ctl.push) begin
            if (self_stays) begin
                n_entry = r_entry;
            end else if (left_stays) begin
                n_entry.vld     = 1'b1;
                n_entry.cls     = i_ctl.cls;
                n_entry.payload = i_ctl.payload;
            end else begin
                n_entry = i_left;
            end
        end
    end

    // valid flag under reset; class and payload carry no reset
    always_ff @(posedge i_clk) begin
        r_entry.cls     <= n_entry.cls;
        r_entry.payload <= n_entry.payload;
        if (!i_rst_n) begin
            r_entry.vld <= 1'b0;
        end else begin
            r_entry.vld <= n_entry.vld;
        end
    end

    assign o_entry = r_entry;

endmodule
